>>> design/sphd_pkg.sv
// ----------------------------------------------------------------------------
// sphd_pkg
// types and constants shared by the density summation unit and its sub-blocks
// ----------------------------------------------------------------------------
`default_nettype none

package sphd_pkg;

   // request action codes
   localparam logic [2:0] ACT_SELF  = 3'd0;
   localparam logic [2:0] ACT_CLEAR = 3'd1;
   localparam logic [2:0] ACT_PAIR  = 3'd2;
   localparam logic [2:0] ACT_ADD   = 3'd3;
   localparam logic [2:0] ACT_WRITE = 3'd4;
   localparam logic [2:0] ACT_READ  = 3'd5;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THREE_DIMENSIONAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_TWO_D        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_THREE_D      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_SMOOTHING = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_SQUARED    = 3'd5;

   // multiplier operand selects
   localparam logic [3:0] MUL_NONE = 4'd0;
   localparam logic [3:0] MUL_DX   = 4'd1;
   localparam logic [3:0] MUL_DY   = 4'd2;
   localparam logic [3:0] MUL_DZ   = 4'd3;
   localparam logic [3:0] MUL_RINV = 4'd4;
   localparam logic [3:0] MUL_K1   = 4'd5;
   localparam logic [3:0] MUL_K2   = 4'd6;
   localparam logic [3:0] MUL_K3   = 4'd7;
   localparam logic [3:0] MUL_WN   = 4'd8;
   localparam logic [3:0] MUL_MB   = 4'd9;
   localparam logic [3:0] MUL_MA   = 4'd10;
   localparam logic [3:0] MUL_SELF = 4'd11;

   // accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // kernel weight selects
   localparam logic [1:0] W_ZERO    = 2'd0;
   localparam logic [1:0] W_CUBIC   = 2'd1;
   localparam logic [1:0] W_QUINTIC = 2'd2;

   // store write selects
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_STORE = 2'd1;
   localparam logic [1:0] WR_ADD_A = 2'd2;
   localparam logic [1:0] WR_ADD_B = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic [11:0]        index_a;
      logic [11:0]        index_b;
      logic [31:0]        mass_a;
      logic [31:0]        mass_b;
      logic               enabled_a;
      logic               enabled_b;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic [31:0]        operand_value;
   } req_type;

   typedef struct packed {
      logic [31:0] density_value;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic        kernel_mode;
      logic        three_dimensional;
      logic [31:0] norm_two_d;
      logic [31:0] norm_three_d;
      logic [31:0] inverse_smoothing;
      logic [31:0] cutoff_squared;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic [3:0] mul_sel;
      logic [1:0] acc_op;
      logic       root_init;
      logic       root_step;
      logic       q_load;
      logic       tmp_load;
      logic       w_load;
      logic [1:0] w_sel;
      logic       weight_load;
      logic       ca_load;
      logic       cb_load;
      logic       rd_b;
      logic [1:0] wr_sel;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       in_cutoff;
      logic       q_big;
      logic       quintic;
   } stat_type;

endpackage

`default_nettype wire

>>> design/sph_density_summation_unit.sv
// ----------------------------------------------------------------------------
// sph_density_summation_unit
// particle density store with spline kernel pair accumulation
// ----------------------------------------------------------------------------
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ------------------------------
//   request   start, busy, req_data               taken when start && !busy
//   result    rsp_valid, rsp_data                 one-cycle strobe, no back-pressure
//   config    csr_we, csr_index, csr_wdata        write when csr_we, no wait
//
// request length differs by action: read, ghost clear / write, self init, add
// and pair; a pair outside the cutoff skips the kernel, otherwise its length
// depends on q past the kernel edge and on the cubic or quintic kernel, and
// is set by the 32-step square root and the single shared multiplier
// the result strobe comes in the first cycle with busy low; a new request may
// be taken in that same cycle since the result sits in an output register
// reset is synchronous and clears the sequencer and the configuration; the
// density store holds no reset value and must be written before it is read
// the receiver cannot stall the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module sph_density_summation_unit #(
   parameter int PARTICLE_COUNT = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             start,
   output logic                                  busy,
   input  sphd_pkg::req_type                     req_data,
   // result channel
   output logic                                  rsp_valid,
   output sphd_pkg::rsp_type                     rsp_data,
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [sphd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_wdata
);
   import sphd_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;
   logic     start_ok;

   // a request is only taken while the sequencer is idle
   assign start_ok = start && !busy;

   // configuration registers
   sphd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: one state per multiply or store access, and one looping state for the root steps
   sphd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start_ok),
      .start_action (req_data.action),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid)
   );

   // store, multiplier, root unit and kernel math
   sphd_datapath #(
      .PARTICLE_COUNT (PARTICLE_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/sphd_csr.sv
// ----------------------------------------------------------------------------
// sphd_csr
// configuration registers of the density summation unit
// ----------------------------------------------------------------------------
`default_nettype none

module sphd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [sphd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_wdata,
   output sphd_pkg::cfg_type                     cfg
);
   import sphd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_mode       <= 1'b0;
         cfg_ff.three_dimensional <= 1'b1;
         cfg_ff.norm_two_d        <= 32'd65536;
         cfg_ff.norm_three_d      <= 32'd65536;
         cfg_ff.inverse_smoothing <= 32'd65536;
         cfg_ff.cutoff_squared    <= 32'd262144;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KERNEL_MODE:       cfg_ff.kernel_mode       <= csr_wdata[0];
            CSR_THREE_DIMENSIONAL: cfg_ff.three_dimensional <= csr_wdata[0];
            CSR_NORM_TWO_D:        cfg_ff.norm_two_d        <= csr_wdata;
            CSR_NORM_THREE_D:      cfg_ff.norm_three_d      <= csr_wdata;
            CSR_INVERSE_SMOOTHING: cfg_ff.inverse_smoothing <= csr_wdata;
            CSR_CUTOFF_SQUARED:    cfg_ff.cutoff_squared    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/sphd_datapath.sv
// ----------------------------------------------------------------------------
// sphd_datapath
// density store, shared multiplier, square root unit and kernel arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module sphd_datapath #(
   parameter int PARTICLE_COUNT = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  sphd_pkg::cfg_type cfg,
   input  sphd_pkg::req_type req_data,
   input  sphd_pkg::cmd_type cmd,
   output sphd_pkg::stat_type stat,
   output sphd_pkg::rsp_type  rsp_data
);
   import sphd_pkg::*;

   localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

   req_type     req_ff;
   logic [63:0] prod_ff, acc_ff;
   logic [32:0] rem_ff, tmp_ff;
   logic [31:0] root_ff, weight_ff, rd_data_ff;
   logic [16:0] q_ff, w_ff;
   logic        big_ff, rd_inr_ff, sat_ff;
   logic [47:0] ca_ff, cb_ff;
   rsp_type     rsp_ff;
   logic [31:0] mem [PARTICLE_COUNT];

   logic [31:0] norm, abs_x, abs_y, abs_z, rd_val;
   logic        quintic, near_cubic;
   logic [17:0] s18, base18;
   logic [18:0] lin19;
   logic [32:0] mul_a, mul_b;
   logic [65:0] product;
   logic [34:0] rem_next;
   logic [33:0] trial;
   logic [52:0] cubic_val;
   logic [16:0] w_in;
   logic [47:0] wr_val48;
   logic [48:0] wr_sum;
   logic [11:0] wr_idx, rd_idx;
   logic        wr_gate, wr_inr, mem_we;
   logic [31:0] wr_data;

   assign norm       = cfg.three_dimensional ? cfg.norm_three_d : cfg.norm_two_d;
   assign quintic    = cfg.kernel_mode;
   assign near_cubic = !quintic && !q_ff[16];
   assign abs_x      = req_ff.delta_x[31] ? (~req_ff.delta_x + 32'd1) : req_ff.delta_x;
   assign abs_y      = req_ff.delta_y[31] ? (~req_ff.delta_y + 32'd1) : req_ff.delta_y;
   assign abs_z      = req_ff.delta_z[31] ? (~req_ff.delta_z + 32'd1) : req_ff.delta_z;
   assign s18        = 18'h20000 - {1'b0, q_ff};
   assign base18     = near_cubic ? {1'b0, q_ff} : s18;
   assign lin19      = {1'b0, q_ff, 1'b0} + 19'd65536;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_DX:   begin mul_a = {1'b0, abs_x};    mul_b = {1'b0, abs_x}; end
         MUL_DY:   begin mul_a = {1'b0, abs_y};    mul_b = {1'b0, abs_y}; end
         MUL_DZ:   begin mul_a = {1'b0, abs_z};    mul_b = {1'b0, abs_z}; end
         MUL_RINV: begin mul_a = {1'b0, root_ff};  mul_b = {1'b0, cfg.inverse_smoothing}; end
         MUL_K1:   begin mul_a = {15'b0, base18};  mul_b = {15'b0, base18}; end
         MUL_K2: begin
            if (quintic) begin
               mul_a = {15'b0, prod_ff[34:17]};
               mul_b = {15'b0, prod_ff[34:17]};
            end else begin
               mul_a = prod_ff[32:0];
               mul_b = {15'b0, base18};
            end
         end
         MUL_K3:   begin mul_a = {15'b0, prod_ff[34:17]}; mul_b = {14'b0, lin19}; end
         MUL_WN:   begin mul_a = {16'b0, w_ff};        mul_b = {1'b0, norm}; end
         MUL_MB:   begin mul_a = {1'b0, req_ff.mass_b}; mul_b = {1'b0, weight_ff}; end
         MUL_MA:   begin mul_a = {1'b0, req_ff.mass_a}; mul_b = {1'b0, weight_ff}; end
         MUL_SELF: begin mul_a = {1'b0, req_ff.mass_a}; mul_b = {1'b0, norm}; end
         default: ;
      endcase
   end

   assign product = mul_a * mul_b;

   // one root bit per step
   assign rem_next = {rem_ff, acc_ff[63:62]};
   assign trial    = {root_ff, 2'b01};

   // cubic inner branch: 2^50 + 3 q^3 - 6 q^2 2^16
   assign cubic_val = (53'd1 << 50)
                    + {5'b0, prod_ff[47:0]} + {4'b0, prod_ff[47:0], 1'b0}
                    - {3'b0, tmp_ff, 17'b0} - {2'b0, tmp_ff, 18'b0};

   always_comb begin
      case (cmd.w_sel)
         W_CUBIC:   w_in = near_cubic ? cubic_val[50:34] : prod_ff[50:34];
         W_QUINTIC: w_in = prod_ff[33:17];
         default:   w_in = '0;
      endcase
   end

   // store write path
   assign rd_val = rd_inr_ff ? rd_data_ff : 32'd0;

   always_comb begin
      wr_gate  = 1'b0;
      wr_idx   = req_ff.index_a;
      wr_val48 = '0;
      wr_sum   = '0;
      case (cmd.wr_sel)
         WR_STORE: begin
            wr_gate = req_ff.enabled_a;
            case (req_ff.action)
               ACT_SELF:  wr_val48 = prod_ff[63:16];
               ACT_WRITE: wr_val48 = {16'b0, req_ff.operand_value};
               default:   wr_val48 = '0;
            endcase
            wr_sum = {1'b0, wr_val48};
         end
         WR_ADD_A: begin
            wr_gate = req_ff.enabled_a;
            wr_sum  = {17'b0, rd_val} + {1'b0, ca_ff};
         end
         WR_ADD_B: begin
            wr_gate = req_ff.enabled_b;
            wr_idx  = req_ff.index_b;
            wr_sum  = {17'b0, rd_val} + {1'b0, cb_ff};
         end
         default: ;
      endcase
   end

   assign wr_data = (|wr_sum[48:32]) ? 32'hFFFF_FFFF : wr_sum[31:0];
   assign wr_inr  = {20'b0, wr_idx} < 32'(PARTICLE_COUNT);
   assign mem_we  = wr_gate && wr_inr;
   assign rd_idx  = cmd.rd_b ? req_ff.index_b : req_ff.index_a;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(wr_idx)] <= wr_data;
      end
      rd_data_ff <= mem[AW'(rd_idx)];
      rd_inr_ff  <= {20'b0, rd_idx} < 32'(PARTICLE_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (cmd.load) begin
         sat_ff <= 1'b0;
      end else if (wr_gate && (|wr_sum[48:32])) begin
         sat_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         ca_ff  <= {16'b0, req_data.operand_value};
      end else if (cmd.ca_load) begin
         ca_ff <= prod_ff[63:16];
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= product[63:0];
      end
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ff;
         ACC_ADD:  acc_ff <= acc_ff + prod_ff;
         default: begin
            if (cmd.root_step) begin
               acc_ff <= {acc_ff[61:0], 2'b00};
            end
         end
      endcase
      if (cmd.root_init) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         if (rem_next >= {1'b0, trial}) begin
            rem_ff  <= 33'(rem_next - {1'b0, trial});
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_next[32:0];
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.q_load) begin
         big_ff <= |prod_ff[63:33];
         q_ff   <= prod_ff[32:16];
      end
      if (cmd.tmp_load) begin
         tmp_ff <= prod_ff[32:0];
      end
      if (cmd.w_load) begin
         w_ff <= w_in;
      end
      if (cmd.weight_load) begin
         weight_ff <= prod_ff[47:16];
      end
      if (cmd.cb_load) begin
         cb_ff <= prod_ff[63:16];
      end
      if (cmd.out_load) begin
         rsp_ff.density_value <= rd_val;
         rsp_ff.saturated     <= sat_ff;
      end
   end

   assign stat.action    = req_ff.action;
   assign stat.in_cutoff = acc_ff < {16'b0, cfg.cutoff_squared, 16'b0};
   assign stat.q_big     = big_ff;
   assign stat.quintic   = quintic;
   assign rsp_data       = rsp_ff;

endmodule

`default_nettype wire

>>> design/sphd_ctrl.sv
// ----------------------------------------------------------------------------
// sphd_ctrl
// sequencer that steps the datapath through each request's action
// ----------------------------------------------------------------------------
`default_nettype none

module sphd_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [2:0]    start_action,
   input  sphd_pkg::stat_type stat,
   output sphd_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import sphd_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_MSELF = 5'd1;
   localparam logic [4:0] S_WSTO  = 5'd2;
   localparam logic [4:0] S_SQX   = 5'd3;
   localparam logic [4:0] S_SQY   = 5'd4;
   localparam logic [4:0] S_SQZ   = 5'd5;
   localparam logic [4:0] S_SUM   = 5'd6;
   localparam logic [4:0] S_CMP   = 5'd7;
   localparam logic [4:0] S_ROOT  = 5'd8;
   localparam logic [4:0] S_QMUL  = 5'd9;
   localparam logic [4:0] S_QLD   = 5'd10;
   localparam logic [4:0] S_K1    = 5'd11;
   localparam logic [4:0] S_K2    = 5'd12;
   localparam logic [4:0] S_K3    = 5'd13;
   localparam logic [4:0] S_K4    = 5'd14;
   localparam logic [4:0] S_WN    = 5'd15;
   localparam logic [4:0] S_WLD   = 5'd16;
   localparam logic [4:0] S_CA    = 5'd17;
   localparam logic [4:0] S_CB    = 5'd18;
   localparam logic [4:0] S_CBL   = 5'd19;
   localparam logic [4:0] S_RDA   = 5'd20;
   localparam logic [4:0] S_ADDA  = 5'd21;
   localparam logic [4:0] S_RDB   = 5'd22;
   localparam logic [4:0] S_ADDB  = 5'd23;
   localparam logic [4:0] S_FRD   = 5'd24;
   localparam logic [4:0] S_FOUT  = 5'd25;

   logic [4:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (start_action)
                  ACT_SELF:  state_in = S_MSELF;
                  ACT_CLEAR: state_in = S_WSTO;
                  ACT_WRITE: state_in = S_WSTO;
                  ACT_PAIR:  state_in = S_SQX;
                  ACT_ADD:   state_in = S_RDA;
                  default:   state_in = S_FRD;
               endcase
            end
         end
         S_MSELF: begin cmd.mul_sel = MUL_SELF; state_in = S_WSTO; end
         S_WSTO:  begin cmd.wr_sel = WR_STORE; state_in = S_FRD; end
         S_SQX:   begin cmd.mul_sel = MUL_DX; state_in = S_SQY; end
         S_SQY: begin
            cmd.mul_sel = MUL_DY;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_SQZ;
         end
         S_SQZ: begin
            cmd.mul_sel = MUL_DZ;
            cmd.acc_op  = ACC_ADD;
            state_in    = S_SUM;
         end
         S_SUM: begin cmd.acc_op = ACC_ADD; state_in = S_CMP; end
         S_CMP: begin
            if (stat.in_cutoff) begin
               cmd.root_init = 1'b1;
               cnt_in        = '0;
               state_in      = S_ROOT;
            end else begin
               state_in = S_FRD;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_QMUL;
            end
         end
         S_QMUL: begin cmd.mul_sel = MUL_RINV; state_in = S_QLD; end
         S_QLD:  begin cmd.q_load = 1'b1; state_in = S_K1; end
         S_K1: begin
            if (stat.q_big) begin
               cmd.w_load = 1'b1;
               cmd.w_sel  = W_ZERO;
               state_in   = S_WN;
            end else begin
               cmd.mul_sel = MUL_K1;
               state_in    = S_K2;
            end
         end
         S_K2: begin
            cmd.mul_sel  = MUL_K2;
            cmd.tmp_load = 1'b1;
            state_in     = S_K3;
         end
         S_K3: begin
            if (stat.quintic) begin
               cmd.mul_sel = MUL_K3;
               state_in    = S_K4;
            end else begin
               cmd.w_load = 1'b1;
               cmd.w_sel  = W_CUBIC;
               state_in   = S_WN;
            end
         end
         S_K4: begin
            cmd.w_load = 1'b1;
            cmd.w_sel  = W_QUINTIC;
            state_in   = S_WN;
         end
         S_WN:  begin cmd.mul_sel = MUL_WN; state_in = S_WLD; end
         S_WLD: begin cmd.weight_load = 1'b1; state_in = S_CA; end
         S_CA:  begin cmd.mul_sel = MUL_MB; state_in = S_CB; end
         S_CB: begin
            cmd.mul_sel = MUL_MA;
            cmd.ca_load = 1'b1;
            state_in    = S_CBL;
         end
         S_CBL: begin cmd.cb_load = 1'b1; state_in = S_RDA; end
         S_RDA: state_in = S_ADDA;
         S_ADDA: begin
            cmd.wr_sel = WR_ADD_A;
            state_in   = (stat.action == ACT_PAIR) ? S_RDB : S_FRD;
         end
         S_RDB:  begin cmd.rd_b = 1'b1; state_in = S_ADDB; end
         S_ADDB: begin cmd.wr_sel = WR_ADD_B; state_in = S_FRD; end
         S_FRD:  state_in = S_FOUT;
         S_FOUT: begin cmd.out_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= cmd.out_load;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire
